### design/dcsd_pkg.sv
// Shared types, opcodes and decode helpers for the draw command stream decoder.
`timescale 1ns / 1ps

package dcsd_pkg;

   typedef enum logic [2:0] {
      KIND_FRAME      = 3'd0,
      KIND_VIEW       = 3'd1,
      KIND_BACKGROUND = 3'd2,
      KIND_SPRITE     = 3'd3,
      KIND_PLAYERS    = 3'd4,
      KIND_SET        = 3'd5,
      KIND_CLEAR      = 3'd6,
      KIND_BAD        = 3'd7
   } kind_type;

   localparam logic [7:0] OP_FRAME     = 8'hff;
   localparam logic [7:0] OP_LAST      = 8'h05;
   localparam int         PAYLOAD_MAX  = 6;
   localparam int         RSP_DATA_W   = 112;

   typedef logic [PAYLOAD_MAX-1:0][7:0] payload_type;

   // One finished command: its kind and the payload bytes that belong to it.
   typedef struct packed {
      kind_type    kind;
      payload_type bytes;
   } cmd_entry_type;

   typedef struct packed {
      kind_type           kind;
      logic [11:0]        pos_x;
      logic [11:0]        pos_y;
      logic [11:0]        second_x;
      logic [11:0]        second_y;
      logic [3:0]         image_group;
      logic [3:0]         sub_image;
      logic [7:0]         cell_x;
      logic [7:0]         cell_y;
      logic signed [31:0] frame_size;
      logic [7:0]         bad_opcode;
   } result_type;

   function automatic logic [2:0] payload_len(input kind_type kind);
      logic [2:0] len;
      case (kind)
         KIND_FRAME:   len = 3'd4;
         KIND_VIEW:    len = 3'd3;
         KIND_SPRITE:  len = 3'd4;
         KIND_PLAYERS: len = 3'd6;
         KIND_SET:     len = 3'd3;
         KIND_CLEAR:   len = 3'd2;
         default:      len = 3'd0;
      endcase
      return len;
   endfunction

   // x takes the low byte and the upper nibble of the middle byte
   function automatic logic [11:0] unpack_x(input logic [7:0] b0, input logic [7:0] b1);
      return {b1[7:4], b0};
   endfunction

   // y takes the lower nibble of the middle byte and the top byte
   function automatic logic [11:0] unpack_y(input logic [7:0] b1, input logic [7:0] b2);
      return {b2, b1[3:0]};
   endfunction

endpackage

### design/dcsd_front.sv
// Byte parser: classifies opcodes, collects payload bytes and emits finished commands.
`timescale 1ns / 1ps

module dcsd_front import dcsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    data_byte,
   input  logic          buffer_start,
   output logic          push,
   output cmd_entry_type push_entry
);

   logic        open_ff, open_in;
   kind_type    kind_ff, kind_in;
   logic [2:0]  seen_ff, seen_in;
   logic        halted_ff, halted_in;
   payload_type payload_ff, payload_in;

   logic        open_eff;
   logic        halt_eff;
   logic [2:0]  seen_eff;
   logic [2:0]  seen_next;
   payload_type merged;
   logic        op_known;
   kind_type    op_kind;

   // a flagged byte drops any open command and lifts a halt
   assign open_eff  = open_ff & ~buffer_start;
   assign halt_eff  = halted_ff & ~buffer_start;
   assign seen_eff  = buffer_start ? 3'd0 : seen_ff;
   assign seen_next = seen_eff + 3'd1;

   always_comb begin
      merged = payload_ff;
      for (int i = 0; i < PAYLOAD_MAX; i++) begin
         if (seen_eff == 3'(i)) begin
            merged[3'(i)] = data_byte;
         end
      end
   end

   always_comb begin
      op_known = 1'b1;
      op_kind  = KIND_BAD;
      if (data_byte == OP_FRAME) begin
         op_kind = KIND_FRAME;
      end else if (data_byte <= OP_LAST) begin
         op_kind = kind_type'(data_byte[2:0] + 3'd1);
      end else begin
         op_known = 1'b0;
      end
   end

   always_comb begin
      open_in    = open_ff;
      kind_in    = kind_ff;
      seen_in    = seen_ff;
      halted_in  = halted_ff;
      payload_in = payload_ff;
      push       = 1'b0;
      push_entry = '0;
      if (accept) begin
         open_in   = open_eff;
         seen_in   = seen_eff;
         halted_in = halt_eff;
         if (!halt_eff) begin
            if (!open_eff) begin
               if (!op_known) begin
                  push                = 1'b1;
                  push_entry.kind     = KIND_BAD;
                  push_entry.bytes[0] = data_byte;
                  halted_in           = 1'b1;
               end else if (payload_len(op_kind) == 3'd0) begin
                  push            = 1'b1;
                  push_entry.kind = op_kind;
               end else begin
                  open_in = 1'b1;
                  kind_in = op_kind;
                  seen_in = 3'd0;
               end
            end else begin
               payload_in = merged;
               seen_in    = seen_next;
               if (seen_next >= payload_len(kind_ff)) begin
                  push             = 1'b1;
                  push_entry.kind  = kind_ff;
                  push_entry.bytes = merged;
                  open_in          = 1'b0;
                  seen_in          = 3'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         kind_ff   <= KIND_FRAME;
         seen_ff   <= 3'd0;
         halted_ff <= 1'b0;
      end else begin
         open_ff   <= open_in;
         kind_ff   <= kind_in;
         seen_ff   <= seen_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

`ifndef ASSERT_OFF
   a_halt_closed: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !open_ff)
      else $error("halted with a command open");

   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (seen_ff < payload_len(kind_ff)))
      else $error("payload count past command length");

   a_bad_halts: assert property (@(posedge clock) disable iff (reset)
      (push && push_entry.kind == KIND_BAD) |=> halted_ff)
      else $error("bad opcode did not halt the parser");
`endif

endmodule

### design/dcsd_queue.sv
// Short command queue between the parser and the result stage.
`timescale 1ns / 1ps

module dcsd_queue import dcsd_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output cmd_entry_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_entry_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

### design/dcsd_back.sv
// Result stage: decodes the queued command into output fields and holds the result.
`timescale 1ns / 1ps

module dcsd_back import dcsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  cmd_entry_type head,
   output logic          pop,
   output logic          out_valid,
   input  logic          out_ready,
   output result_type    out_result
);

   logic       valid_ff, valid_in;
   result_type result_ff;
   result_type decoded;

   always_comb begin
      decoded      = '0;
      decoded.kind = head.kind;
      case (head.kind)
         KIND_FRAME: begin
            decoded.frame_size = {head.bytes[3], head.bytes[2], head.bytes[1], head.bytes[0]};
         end
         KIND_VIEW: begin
            decoded.pos_x = unpack_x(head.bytes[0], head.bytes[1]);
            decoded.pos_y = unpack_y(head.bytes[1], head.bytes[2]);
         end
         KIND_SPRITE: begin
            decoded.pos_x       = unpack_x(head.bytes[0], head.bytes[1]);
            decoded.pos_y       = unpack_y(head.bytes[1], head.bytes[2]);
            decoded.image_group = head.bytes[3][7:4];
            decoded.sub_image   = head.bytes[3][3:0];
         end
         KIND_PLAYERS: begin
            decoded.pos_x    = unpack_x(head.bytes[0], head.bytes[1]);
            decoded.pos_y    = unpack_y(head.bytes[1], head.bytes[2]);
            decoded.second_x = unpack_x(head.bytes[3], head.bytes[4]);
            decoded.second_y = unpack_y(head.bytes[4], head.bytes[5]);
         end
         KIND_SET: begin
            decoded.cell_x      = head.bytes[0];
            decoded.cell_y      = head.bytes[1];
            decoded.image_group = head.bytes[2][7:4];
            decoded.sub_image   = head.bytes[2][3:0];
         end
         KIND_CLEAR: begin
            decoded.cell_x = head.bytes[0];
            decoded.cell_y = head.bytes[1];
         end
         KIND_BAD: begin
            decoded.bad_opcode = head.bytes[0];
         end
         default: begin
            decoded.kind = head.kind;
         end
      endcase
   end

   // load whenever the output register is empty or being drained this cycle
   assign pop = head_valid & (~valid_ff | out_ready);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= decoded;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

### design/draw_command_stream_decoder.sv
// Top level of the draw command stream decoder: ports, beat packing and part wiring.
`timescale 1ns / 1ps
//
// Usage:
//   req_ channel carries one command-stream byte per beat in req_tdata; req_tuser
//   flags the first byte of a new buffer, which drops any partial command, lifts
//   a halt and is parsed as an opcode.
//   rsp_ channel carries one decoded command per beat: the kind in rsp_tuser and
//   every decoded field in rsp_tdata, fields a kind does not use held at zero.
//   An unknown opcode gives a bad-opcode beat; bytes are then dropped until a
//   flagged byte arrives.
// Timing:
//   The beat that completes a command writes it into the queue; it then moves to
//   the result register and appears on rsp_tvalid. Throughput is one byte per cycle
//   while the queue has room, set by the parser and the result register's one-per-cycle drain.
// Stall:
//   Finished commands wait in a QUEUE_DEPTH-entry queue; req_tready drops only
//   when that queue is full, so the receiver may stall freely.
// Reset:
//   Synchronous; clears the parser state, the queue and the result valid flag. No
//   clearing pass is needed, so req_tready is high the cycle after reset.
//
module draw_command_stream_decoder import dcsd_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte[7:0]
   input  logic                  req_tuser,   // buffer_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pos_x[11:0], pos_y[23:12], second_x[35:24], second_y[47:36],
   // image_group[51:48], sub_image[55:52], cell_x[63:56], cell_y[71:64],
   // frame_size[103:72], bad_opcode[111:104]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser    // kind[2:0]
);

   logic          accept;
   logic          push;
   cmd_entry_type push_entry;
   logic          queue_full;
   logic          queue_not_empty;
   cmd_entry_type queue_head;
   logic          pop;
   result_type    result;

   // take a beat whenever the queue has room for the command it may finish
   assign req_tready = ~queue_full;
   assign accept     = req_tvalid & req_tready;

   dcsd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .buffer_start (req_tuser),
      .push         (push),
      .push_entry   (push_entry)
   );

   dcsd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (queue_head)
   );

   dcsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head       (queue_head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // pack the result fields, first field lowest
   assign rsp_tuser = result.kind;
   assign rsp_tdata = {result.bad_opcode,
                       result.frame_size,
                       result.cell_y,
                       result.cell_x,
                       result.sub_image,
                       result.image_group,
                       result.second_y,
                       result.second_x,
                       result.pos_y,
                       result.pos_x};

endmodule
